// File: design/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check that holds in the same cycle as its trigger
`define ASSERT_IMPLIES(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// check that holds in the cycle after its trigger
`define ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: design/c3x3_pkg.sv
`default_nettype none

package c3x3_pkg;

  // default sizing
  localparam int unsigned DefMaxWidth  = 1024;
  localparam int unsigned DefMaxHeight = 1024;
  localparam int unsigned DefLanes     = 4;

  // fixed field widths
  localparam int unsigned SampleW  = 8;
  localparam int unsigned PortLanes = 4;
  localparam int unsigned WinTaps  = 9;
  localparam int unsigned KernelW  = 3;
  localparam int unsigned DimW     = 11;
  localparam int unsigned CountW   = 3;
  localparam int unsigned CoordW   = 10;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 11;

  // coefficient arithmetic
  localparam int unsigned FracW      = 16;
  localparam int unsigned GaussShift = 4;
  localparam int unsigned BoxRecipW  = 13;
  localparam logic [BoxRecipW-1:0] BoxRecip = 13'd7282;

  // result queue
  localparam int unsigned FifoDepth = 4;

  typedef enum logic [KernelW-1:0] {
    K_EDGE     = 3'd0,
    K_SHARPEN  = 3'd1,
    K_BOX      = 3'd2,
    K_GAUSS    = 3'd3,
    K_EMBOSS   = 3'd4,
    K_IDENTITY = 3'd5
  } kernel_e;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_KERNEL_SELECT = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_IMAGE_WIDTH   = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_IMAGE_HEIGHT  = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_CHANNEL_COUNT = 2'd3;

  // register reset values
  localparam logic [DimW-1:0]   DimReset      = 11'd1024;
  localparam logic [CountW-1:0] ChannelsReset = 3'd4;

endpackage

`default_nettype wire

// File: design/c3x3_lane.sv
`default_nettype none

module c3x3_lane import c3x3_pkg::*; (
  input  kernel_e                         kernel_i,
  input  logic [WinTaps-1:0][SampleW-1:0] win_i,
  output logic [SampleW-1:0]              value_o
);

  // wide enough for any weighted sum of nine samples
  localparam int unsigned AccW  = 13;
  localparam int unsigned ProdW = AccW + BoxRecipW;

  logic [AccW-1:0]  p [WinTaps];
  logic [AccW-1:0]  sum9;
  logic [AccW-1:0]  gsum;
  logic [ProdW-1:0] box_prod;
  logic [AccW-1:0]  acc;

  // zero-extend the taps
  always_comb begin
    for (int i = 0; i < WinTaps; i++) begin
      p[i] = AccW'(win_i[i]);
    end
  end

  // plain and gaussian-weighted sums
  assign sum9 = ((p[0] + p[1]) + (p[2] + p[3])) + ((p[4] + p[5]) + (p[6] + p[7])) + p[8];
  assign gsum = (p[0] + p[2] + p[6] + p[8]) + ((p[1] + p[3] + p[5] + p[7]) << 1)
              + (p[4] << 2);

  // box blur: multiply by the Q16 reciprocal of nine
  assign box_prod = ProdW'(sum9) * ProdW'(BoxRecip);

  // integer kernels wrap modulo 2^AccW, only the low byte is kept
  always_comb begin
    case (kernel_i)
      K_EDGE:    acc = (p[4] << 2) - p[1] - p[3] - p[5] - p[7];
      K_SHARPEN: acc = (p[4] << 2) + p[4] - p[1] - p[3] - p[5] - p[7];
      K_BOX:     acc = AccW'(box_prod[FracW +: SampleW]);
      K_GAUSS:   acc = AccW'(gsum[GaussShift +: SampleW]);
      K_EMBOSS:  acc = p[4] + p[5] + p[7] + (p[8] << 1) - (p[0] << 1) - p[1] - p[3];
      default:   acc = p[4];
    endcase
  end

  assign value_o = acc[SampleW-1:0];

endmodule

`default_nettype wire

// File: design/convolution_3x3_clamped_edges.sv
// 3x3 image convolution over a raster pixel stream, borders replicated.
// Input channel: in_valid_i / in_stall_o with kind_i and sample_c0..3_i.
//   kind_i 0 is a pixel, kind_i 1 a flush tick; after the last pixel row,
//   one flush tick per column drains the final output row.
// Output channel: out_valid_o / out_stall_i, one output pixel per item,
//   with its column, row, last_of_run (last result of an input item) and
//   end_of_frame flags. A pixel in row 0 gives nothing; other items give one result
//   except in column 0, and the last item of a row gives one more.
// Config: cfg_we_i writes register cfg_index_i with cfg_data_i; write only
//   while no item is in flight.
// Path: an accepted item is registered in stage 1, then its results enter the result queue.
// Throughput: one item per cycle while in_stall_o is low; a row-end item that gives
//   two results can hold the input back, since the output port moves one result
//   per cycle. A four-entry result queue lets input continue while the
//   receiver stalls; in_stall_o rises when the queue could overflow.
// Reset: registers return to identity kernel, 1024x1024, four channels,
//   the frame position goes to the first pixel, the queue empties.
//   Line stores are not cleared; every entry is written before its value is used.
`default_nettype none
`include "assert_macros.svh"

module convolution_3x3_clamped_edges import c3x3_pkg::*; #(
  parameter int unsigned MAX_WIDTH  = DefMaxWidth,
  parameter int unsigned MAX_HEIGHT = DefMaxHeight,
  parameter int unsigned LANES      = DefLanes
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  // input items
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                kind_i,
  input  logic [SampleW-1:0]  sample_c0_i,
  input  logic [SampleW-1:0]  sample_c1_i,
  input  logic [SampleW-1:0]  sample_c2_i,
  input  logic [SampleW-1:0]  sample_c3_i,
  // result items
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [SampleW-1:0]  result_c0_o,
  output logic [SampleW-1:0]  result_c1_o,
  output logic [SampleW-1:0]  result_c2_o,
  output logic [SampleW-1:0]  result_c3_o,
  output logic [CoordW-1:0]   out_column_o,
  output logic [CoordW-1:0]   out_row_o,
  output logic                last_of_run_o,
  output logic                end_of_frame_o
);

  localparam int unsigned CW   = $clog2(MAX_WIDTH);
  localparam int unsigned RW   = $clog2(MAX_HEIGHT);
  localparam int unsigned DWW  = ($clog2(MAX_WIDTH + 1) > DimW) ? $clog2(MAX_WIDTH + 1) : DimW;
  localparam int unsigned DWH  = ($clog2(MAX_HEIGHT + 1) > DimW) ?
                                 $clog2(MAX_HEIGHT + 1) : DimW;
  localparam int unsigned PtrW = $clog2(FifoDepth);
  localparam int unsigned CntW = $clog2(FifoDepth + 1);

  typedef logic [LANES-1:0][SampleW-1:0] pix_t;

  typedef struct packed {
    logic          emit1;
    logic          emit2;
    logic          first;
    logic          drain;
    logic [CW-1:0] col;
    logic [RW-1:0] row;
  } s1_ctrl_t;

  typedef struct packed {
    logic [PortLanes-1:0][SampleW-1:0] lanes;
    logic [CoordW-1:0]                 col;
    logic [CoordW-1:0]                 row;
    logic                              last;
    logic                              eof;
  } res_t;

  // configuration registers
  logic [KernelW-1:0] kernel_select_q;
  logic [DimW-1:0]    image_width_q;
  logic [DimW-1:0]    image_height_q;
  logic [CountW-1:0]  channel_count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kernel_select_q <= K_IDENTITY;
      image_width_q   <= DimReset;
      image_height_q  <= DimReset;
      channel_count_q <= ChannelsReset;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_KERNEL_SELECT: kernel_select_q <= cfg_data_i[KernelW-1:0];
        CFG_IMAGE_WIDTH:   image_width_q   <= cfg_data_i[DimW-1:0];
        CFG_IMAGE_HEIGHT:  image_height_q  <= cfg_data_i[DimW-1:0];
        CFG_CHANNEL_COUNT: channel_count_q <= cfg_data_i[CountW-1:0];
        default: ;
      endcase
    end
  end

  // frame position
  logic [CW-1:0] col_q;
  logic [RW-1:0] row_q;
  logic          draining_q;

  // effective last column and last row, zero treated as one, large values saturated
  logic [DWW-1:0] wid_ext;
  logic [DWH-1:0] hgt_ext;
  logic [CW-1:0]  w_last;
  logic [RW-1:0]  h_last;

  assign wid_ext = DWW'(image_width_q);
  assign hgt_ext = DWH'(image_height_q);

  always_comb begin
    if (wid_ext == '0) begin
      w_last = '0;
    end else if (wid_ext > DWW'(MAX_WIDTH)) begin
      w_last = CW'(MAX_WIDTH - 1);
    end else begin
      w_last = CW'(wid_ext - 1'b1);
    end
    if (hgt_ext == '0) begin
      h_last = '0;
    end else if (hgt_ext > DWH'(MAX_HEIGHT)) begin
      h_last = RW'(MAX_HEIGHT - 1);
    end else begin
      h_last = RW'(hgt_ext - 1'b1);
    end
  end

  // input side decode
  logic          in_acc;
  logic          proc;
  logic          first_row;
  logic          row_end;
  logic [RW-1:0] out_y;

  assign in_acc    = in_valid_i && !in_stall_o;
  // flush outside draining and pixels while draining are dropped
  assign proc      = in_acc && (kind_i == draining_q);
  assign first_row = !draining_q && (row_q == '0);
  assign row_end   = col_q >= w_last;
  assign out_y     = draining_q ? row_q : row_q - 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      draining_q <= 1'b0;
    end else if (proc) begin
      if (row_end) begin
        col_q <= '0;
        if (draining_q) begin
          draining_q <= 1'b0;
          row_q      <= '0;
        end else if (row_q >= h_last) begin
          draining_q <= 1'b1;
        end else begin
          row_q <= row_q + 1'b1;
        end
      end else begin
        col_q <= col_q + 1'b1;
      end
    end
  end

  // pack the incoming pixel
  logic [PortLanes-1:0][SampleW-1:0] samp_all;
  pix_t                              fresh;

  assign samp_all = {sample_c3_i, sample_c2_i, sample_c1_i, sample_c0_i};

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      fresh[l] = samp_all[l];
    end
  end

  // stage 1 registers
  logic     s1_valid_q;
  s1_ctrl_t s1_q;
  pix_t     s1_fresh_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= proc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc) begin
      s1_q.emit1 <= !first_row && (col_q != '0);
      s1_q.emit2 <= !first_row && row_end;
      s1_q.first <= first_row;
      s1_q.drain <= draining_q;
      s1_q.col   <= col_q;
      s1_q.row   <= out_y;
      s1_fresh_q <= fresh;
    end
  end

  // line stores, read data registered
  pix_t mid_mem [MAX_WIDTH];
  pix_t upper_mem [MAX_WIDTH];
  pix_t mid_rd_q;
  pix_t up_rd_q;
  logic up_we;
  pix_t up_wdata;

  // middle row: read old entry and write the new pixel at the same column
  always_ff @(posedge clk_i) begin
    if (proc && !draining_q) begin
      mid_mem[col_q] <= fresh;
    end
    if (proc) begin
      mid_rd_q <= mid_mem[col_q];
    end
  end

  // upper row takes the old middle entry in the cycle after it is read (the fresh pixel in row 0)
  assign up_we    = s1_valid_q && !s1_q.drain;
  assign up_wdata = s1_q.first ? s1_fresh_q : mid_rd_q;

  always_ff @(posedge clk_i) begin
    if (up_we) begin
      upper_mem[s1_q.col] <= up_wdata;
    end
    if (proc) begin
      // bypass the pending write to the same column (single-column frames)
      up_rd_q <= (up_we && (s1_q.col == col_q)) ? up_wdata : upper_mem[col_q];
    end
  end

  // column of three rows entering the window
  pix_t [2:0] vcol;

  always_comb begin
    if (s1_q.drain) begin
      vcol[0] = up_rd_q;
      vcol[1] = mid_rd_q;
      vcol[2] = mid_rd_q;
    end else if (s1_q.first) begin
      vcol[0] = s1_fresh_q;
      vcol[1] = s1_fresh_q;
      vcol[2] = s1_fresh_q;
    end else begin
      vcol[0] = up_rd_q;
      vcol[1] = mid_rd_q;
      vcol[2] = s1_fresh_q;
    end
  end

  // window shift, left edge replicated at column zero
  pix_t [WinTaps-1:0] win_q;
  pix_t [WinTaps-1:0] win_d;
  pix_t [WinTaps-1:0] shift_v;
  logic               col_zero;

  assign col_zero = (s1_q.col == '0);

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      if (col_zero) begin
        win_d[3*r]   = vcol[r];
        win_d[3*r+1] = vcol[r];
      end else begin
        win_d[3*r]   = win_q[3*r+1];
        win_d[3*r+1] = win_q[3*r+2];
      end
      win_d[3*r+2]   = vcol[r];
      // right edge replicated for the last column
      shift_v[3*r]   = win_d[3*r+1];
      shift_v[3*r+1] = vcol[r];
      shift_v[3*r+2] = vcol[r];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= '0;
    end else if (s1_valid_q) begin
      win_q <= win_d;
    end
  end

  // per-lane kernel sums for both possible results
  logic [PortLanes-1:0][SampleW-1:0] lanes_a;
  logic [PortLanes-1:0][SampleW-1:0] lanes_b;

  for (genvar l = 0; l < PortLanes; l++) begin : g_lane
    if (l < LANES) begin : g_on
      logic [WinTaps-1:0][SampleW-1:0] tap_a;
      logic [WinTaps-1:0][SampleW-1:0] tap_b;
      logic [SampleW-1:0]              val_a;
      logic [SampleW-1:0]              val_b;
      logic                            lane_en;

      always_comb begin
        for (int i = 0; i < WinTaps; i++) begin
          tap_a[i] = win_d[i][l];
          tap_b[i] = shift_v[i][l];
        end
      end

      c3x3_lane u_sum_a (
        .kernel_i (kernel_e'(kernel_select_q)),
        .win_i    (tap_a),
        .value_o  (val_a)
      );

      c3x3_lane u_sum_b (
        .kernel_i (kernel_e'(kernel_select_q)),
        .win_i    (tap_b),
        .value_o  (val_b)
      );

      assign lane_en    = CountW'(l) < channel_count_q;
      assign lanes_a[l] = lane_en ? val_a : '0;
      assign lanes_b[l] = lane_en ? val_b : '0;
    end else begin : g_off
      assign lanes_a[l] = '0;
      assign lanes_b[l] = '0;
    end
  end

  // result items of the stage 1 input item
  res_t res_a;
  res_t res_b;

  always_comb begin
    res_a.lanes = lanes_a;
    res_a.col   = CoordW'(s1_q.col - 1'b1);
    res_a.row   = CoordW'(s1_q.row);
    res_a.last  = !s1_q.emit2;
    res_a.eof   = 1'b0;
    res_b.lanes = lanes_b;
    res_b.col   = CoordW'(s1_q.col);
    res_b.row   = CoordW'(s1_q.row);
    res_b.last  = 1'b1;
    res_b.eof   = s1_q.drain;
  end

  // result queue
  res_t            fifo_q [FifoDepth];
  logic [PtrW-1:0] wr_ptr_q;
  logic [PtrW-1:0] rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic [1:0]      push_n;
  logic            pop;
  logic [CntW:0]   need;

  assign push_n = s1_valid_q ? ({1'b0, s1_q.emit1} + {1'b0, s1_q.emit2}) : 2'd0;
  assign pop    = out_valid_o && !out_stall_i;

  always_ff @(posedge clk_i) begin
    if (s1_valid_q && s1_q.emit1) begin
      fifo_q[wr_ptr_q] <= res_a;
    end
    if (s1_valid_q && s1_q.emit2) begin
      fifo_q[wr_ptr_q + PtrW'(s1_q.emit1)] <= res_b;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + PtrW'(push_n);
      rd_ptr_q <= rd_ptr_q + PtrW'(pop);
      cnt_q    <= cnt_q + CntW'(push_n) - CntW'(pop);
    end
  end

  // room for the results of the item in stage 1 and two more for a new item
  assign need       = {1'b0, cnt_q} + (CntW+1)'(push_n) + (CntW+1)'(2);
  assign in_stall_o = need > (CntW+1)'(FifoDepth);

  // output port
  assign out_valid_o    = cnt_q != '0;
  assign result_c0_o    = fifo_q[rd_ptr_q].lanes[0];
  assign result_c1_o    = fifo_q[rd_ptr_q].lanes[1];
  assign result_c2_o    = fifo_q[rd_ptr_q].lanes[2];
  assign result_c3_o    = fifo_q[rd_ptr_q].lanes[3];
  assign out_column_o   = fifo_q[rd_ptr_q].col;
  assign out_row_o      = fifo_q[rd_ptr_q].row;
  assign last_of_run_o  = fifo_q[rd_ptr_q].last;
  assign end_of_frame_o = fifo_q[rd_ptr_q].eof;

  // checks
  `ASSERT_IMPLIES(a_fifo_bound, 1'b1, cnt_q <= CntW'(FifoDepth))
  `ASSERT_IMPLIES(a_eof_is_last, out_valid_o && end_of_frame_o, last_of_run_o)
  `ASSERT_IMPLIES(a_first_row_quiet, s1_valid_q && s1_q.first, !s1_q.emit1 && !s1_q.emit2)
  `ASSERT_NEXT(a_drain_ends, proc && draining_q && row_end, !draining_q && row_q == '0)

endmodule

`default_nettype wire

// File: dv/convolution_3x3_clamped_edges_tb.sv
`timescale 1ns / 100ps

module convolution_3x3_clamped_edges_tb;
  import c3x3_pkg::*;

  localparam int Q1         = 65536;
  localparam int BoxTap     = 7282;
  localparam int QuietLimit = 4000;
  localparam int HoldCycles = 300;
  localparam int SettleGap  = 8;

  // kernel codes past the defined set, both behave as identity
  localparam logic [KernelW-1:0] KernelRsvd6 = 3'd6;
  localparam logic [KernelW-1:0] KernelRsvd7 = 3'd7;

  typedef logic [31:0] window_t [9];
  typedef int coeff_t [9];

  typedef struct packed {
    logic [3:0][7:0] px;
    logic [9:0]      col;
    logic [9:0]      row;
    logic            last;
    logic            eof;
  } out_pixel_t;

  // tracks the convolution state and the output pixels still owed
  class conv_checker;
    logic [KernelW-1:0] kernel;
    logic [DimW-1:0]    width_reg;
    logic [DimW-1:0]    height_reg;
    logic [CountW-1:0]  lanes_used;
    logic [31:0]        upper_row [DefMaxWidth];
    logic [31:0]        middle_row [DefMaxWidth];
    window_t            win;
    int unsigned        col_in;
    int unsigned        row_in;
    bit                 draining;
    out_pixel_t         pending_pixels [$];
    int                 errors;
    int                 frames_done;
    int                 live_items;

    function new();
      kernel      = K_IDENTITY;
      width_reg   = DimReset;
      height_reg  = DimReset;
      lanes_used  = ChannelsReset;
      foreach (win[i]) win[i] = '0;
      col_in      = 0;
      row_in      = 0;
      draining    = 1'b0;
      errors      = 0;
      frames_done = 0;
      live_items  = 0;
    endfunction

    function void set_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
      case (idx)
        CFG_KERNEL_SELECT: kernel = data[KernelW-1:0];
        CFG_IMAGE_WIDTH:   width_reg = data[DimW-1:0];
        CFG_IMAGE_HEIGHT:  height_reg = data[DimW-1:0];
        CFG_CHANNEL_COUNT: lanes_used = data[CountW-1:0];
        default: ;
      endcase
    endfunction

    // nine-tap sum with signed Q15.16 coefficients, truncated toward zero, low byte kept
    function logic [7:0] convolve_lane(window_t src, int lane);
      coeff_t coeffs;
      longint acc;
      longint mag;
      longint q;
      case (kernel)
        K_EDGE:    coeffs = '{0, -Q1, 0, -Q1, 4*Q1, -Q1, 0, -Q1, 0};
        K_SHARPEN: coeffs = '{0, -Q1, 0, -Q1, 5*Q1, -Q1, 0, -Q1, 0};
        K_BOX:     coeffs = '{BoxTap, BoxTap, BoxTap, BoxTap, BoxTap,
                              BoxTap, BoxTap, BoxTap, BoxTap};
        K_GAUSS:   coeffs = '{4096, 8192, 4096, 8192, 16384, 8192, 4096, 8192, 4096};
        K_EMBOSS:  coeffs = '{-2*Q1, -Q1, 0, -Q1, Q1, Q1, 0, Q1, 2*Q1};
        default:   coeffs = '{0, 0, 0, 0, Q1, 0, 0, 0, 0};
      endcase
      acc = 0;
      for (int i = 0; i < 9; i++)
        acc += longint'(coeffs[i]) * longint'({24'd0, src[i][8*lane +: 8]});
      mag = (acc < 0) ? -acc : acc;
      q = mag >> FracW;
      if (acc < 0) q = -q;
      return q[7:0];
    endfunction

    function out_pixel_t build_pixel(window_t src, int unsigned x, int unsigned y, bit eof);
      out_pixel_t p;
      for (int l = 0; l < 4; l++)
        p.px[l] = (l < lanes_used) ? convolve_lane(src, l) : 8'd0;
      p.col  = 10'(x);
      p.row  = 10'(y);
      p.last = 1'b0;
      p.eof  = eof;
      return p;
    endfunction

    // one accepted input item: advance the window and queue its output pixels
    function void take_item(bit flush, logic [31:0] fresh);
      int unsigned w;
      int unsigned h;
      int unsigned c;
      int unsigned y;
      logic [31:0] top;
      logic [31:0] mid;
      logic [31:0] bot;
      logic [31:0] v;
      window_t     shifted;
      bit          first_row;
      bit          row_end;
      out_pixel_t  burst [$];

      // wrong kind for the current phase is dropped
      if (flush != draining) return;
      live_items++;

      w = (width_reg == 0) ? 1 : ((width_reg > DefMaxWidth) ? DefMaxWidth : width_reg);
      h = (height_reg == 0) ? 1 : ((height_reg > DefMaxHeight) ? DefMaxHeight : height_reg);
      c = (col_in >= DefMaxWidth) ? DefMaxWidth - 1 : col_in;

      // column of three from the line stores
      first_row = !draining && row_in == 0;
      if (draining) begin
        top = upper_row[c];
        mid = middle_row[c];
        bot = mid;
      end else if (first_row) begin
        top = fresh;
        mid = fresh;
        bot = fresh;
        upper_row[c]  = fresh;
        middle_row[c] = fresh;
      end else begin
        top = upper_row[c];
        mid = middle_row[c];
        bot = fresh;
        upper_row[c]  = mid;
        middle_row[c] = fresh;
      end

      // shift the window, left edge replicated at column zero
      for (int r = 0; r < 3; r++) begin
        v = (r == 0) ? top : ((r == 1) ? mid : bot);
        if (c == 0) begin
          win[3*r]   = v;
          win[3*r+1] = v;
        end else begin
          win[3*r]   = win[3*r+1];
          win[3*r+1] = win[3*r+2];
        end
        win[3*r+2]     = v;
        shifted[3*r]   = win[3*r+1];
        shifted[3*r+1] = v;
        shifted[3*r+2] = v;
      end

      // output pixels one row behind, right edge replicated at row end
      row_end = c >= w - 1;
      if (!first_row) begin
        y = draining ? row_in : row_in - 1;
        if (c >= 1) burst.push_back(build_pixel(win, c - 1, y, 1'b0));
        if (row_end) burst.push_back(build_pixel(shifted, c, y, draining));
        if (burst.size() > 0) burst[burst.size()-1].last = 1'b1;
        foreach (burst[i]) pending_pixels.push_back(burst[i]);
      end

      // raster position
      if (row_end) begin
        col_in = 0;
        if (draining) begin
          draining = 1'b0;
          row_in   = 0;
          frames_done++;
        end else if (row_in >= h - 1) begin
          draining = 1'b1;
        end else begin
          row_in++;
        end
      end else begin
        col_in = c + 1;
      end
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_pixel(out_pixel_t got);
      out_pixel_t want;
      if (pending_pixels.size() == 0) begin
        $error("output pixel column %0d row %0d with none outstanding", got.col, got.row);
        errors++;
        return;
      end
      want = pending_pixels.pop_front();
      for (int l = 0; l < 4; l++)
        compare_field($sformatf("result_c%0d", l), want.px[l], got.px[l]);
      compare_field("out_column", want.col, got.col);
      compare_field("out_row", want.row, got.row);
      compare_field("last_of_run", want.last, got.last);
      compare_field("end_of_frame", want.eof, got.eof);
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;
  logic                in_valid_i;
  logic                in_stall_o;
  logic                kind_i;
  logic [SampleW-1:0]  sample_c0_i;
  logic [SampleW-1:0]  sample_c1_i;
  logic [SampleW-1:0]  sample_c2_i;
  logic [SampleW-1:0]  sample_c3_i;
  logic                out_valid_o;
  logic                out_stall_i;
  logic [SampleW-1:0]  result_c0_o;
  logic [SampleW-1:0]  result_c1_o;
  logic [SampleW-1:0]  result_c2_o;
  logic [SampleW-1:0]  result_c3_o;
  logic [CoordW-1:0]   out_column_o;
  logic [CoordW-1:0]   out_row_o;
  logic                last_of_run_o;
  logic                end_of_frame_o;

  conv_checker sb = new();
  out_pixel_t  seen_px;
  int          gap_pct;
  int          stall_pct;
  int          noise_pct;
  bit          extreme_samples;
  bit          hold_req;
  int          quiet;

  convolution_3x3_clamped_edges u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .kind_i         (kind_i),
    .sample_c0_i    (sample_c0_i),
    .sample_c1_i    (sample_c1_i),
    .sample_c2_i    (sample_c2_i),
    .sample_c3_i    (sample_c3_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .result_c0_o    (result_c0_o),
    .result_c1_o    (result_c1_o),
    .result_c2_o    (result_c2_o),
    .result_c3_o    (result_c3_o),
    .out_column_o   (out_column_o),
    .out_row_o      (out_row_o),
    .last_of_run_o  (last_of_run_o),
    .end_of_frame_o (end_of_frame_o)
  );

  // clock
  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // receiver: random stalls, plus a long hold-off on request
  initial begin : out_side
    int hold;
    hold = 0;
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        hold = HoldCycles;
      end
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        hold--;
      end else begin
        out_stall_i <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  // output check and watchdog, sampled mid-cycle
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        seen_px.px   = {result_c3_o, result_c2_o, result_c1_o, result_c0_o};
        seen_px.col  = out_column_o;
        seen_px.row  = out_row_o;
        seen_px.last = last_of_run_o;
        seen_px.eof  = end_of_frame_o;
        sb.check_pixel(seen_px);
      end
      if ((out_valid_o && !out_stall_i) || (in_valid_i && !in_stall_o)) begin
        quiet = 0;
      end else begin
        quiet++;
        if (quiet >= QuietLimit) begin
          $display("convolution_3x3_clamped_edges_tb: done, errors");
          $finish;
        end
      end
    end
  end

  function automatic logic [7:0] pick_sample();
    if (extreme_samples) return $urandom_range(1) ? 8'hff : 8'h00;
    case ($urandom_range(7))
      0:       return 8'h00;
      1:       return 8'hff;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // offer one item and wait for it to be taken
  task automatic push_item(input bit flush);
    int          gap;
    logic [7:0]  s [4];
    bit          hit;
    gap = 0;
    while (gap < 60 && $urandom_range(99) < gap_pct) gap++;
    foreach (s[l]) s[l] = pick_sample();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    kind_i      <= flush;
    sample_c0_i <= s[0];
    sample_c1_i <= s[1];
    sample_c2_i <= s[2];
    sample_c3_i <= s[3];
    hit = 1'b0;
    while (!hit) begin
      @(negedge clk_i);
      hit = !in_stall_o;
      @(posedge clk_i);
    end
    sb.take_item(flush, {s[3], s[2], s[1], s[0]});
  endtask

  // items of the current frame until it ends or max_items are sent
  task automatic stream_frame(input int max_items);
    int sent;
    int start;
    bit flush;
    sent  = 0;
    start = sb.frames_done;
    while (sb.frames_done == start && sent < max_items) begin
      flush = sb.draining;
      if ($urandom_range(99) < noise_pct) flush = !flush;
      push_item(flush);
      sent++;
    end
  endtask

  // wait until every output pixel is in and the block has gone quiet
  task automatic settle();
    in_valid_i <= 1'b0;
    while (sb.pending_pixels.size() != 0) @(posedge clk_i);
    repeat (SettleGap) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    sb.set_reg(idx, data);
  endtask

  task automatic configure(input logic [KernelW-1:0] k, input int unsigned w,
                           input int unsigned h, input int unsigned ch);
    settle();
    cfg_write(CFG_KERNEL_SELECT, CfgDataW'(k));
    cfg_write(CFG_IMAGE_WIDTH, CfgDataW'(w));
    cfg_write(CFG_IMAGE_HEIGHT, CfgDataW'(h));
    cfg_write(CFG_CHANNEL_COUNT, CfgDataW'(ch));
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_idling(input int mode);
    case (mode)
      0: begin gap_pct = 0;  stall_pct = 0;  end
      1: begin gap_pct = 86; stall_pct = 0;  end
      2: begin gap_pct = 0;  stall_pct = 86; end
      default: begin gap_pct = 19; stall_pct = 19; end
    endcase
  endtask

  initial begin : stimulus
    int target;
    int frame_no;
    int pick;
    int unsigned w;
    int unsigned h;
    int unsigned ch;

    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_index_i     = '0;
    cfg_data_i      = '0;
    in_valid_i      = 1'b0;
    kind_i          = 1'b0;
    sample_c0_i     = '0;
    sample_c1_i     = '0;
    sample_c2_i     = '0;
    sample_c3_i     = '0;
    gap_pct         = 0;
    stall_pct       = 0;
    noise_pct       = 0;
    extreme_samples = 1'b0;
    hold_req        = 1'b0;
    quiet           = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // emboss on extreme samples, a stray flush and a stray pixel
    extreme_samples = 1'b1;
    configure(K_EMBOSS, 3, 2, 4);
    push_item(1'b1);
    stream_frame(7);
    push_item(1'b0);
    stream_frame(100);

    // zero sizes and no channels with an undefined kernel code
    configure(KernelRsvd6, 0, 0, 0);
    stream_frame(100);

    // channel count past the lane count, other undefined kernel code
    configure(KernelRsvd7, 2, 1, 7);
    stream_frame(100);

    // edge kernel, one channel
    configure(K_EDGE, 2, 2, 1);
    stream_frame(100);
    extreme_samples = 1'b0;

    // frame shrunk in width and height partway through row two
    configure(K_BOX, 5, 4, 3);
    stream_frame(13);
    configure(K_BOX, 2, 3, 3);
    stream_frame(100);

    // receiver holds off while the sender keeps pushing
    configure(K_GAUSS, 10, 6, 4);
    hold_req = 1'b1;
    stream_frame(1000);

    // random frames, mostly small, rotating through idling patterns
    noise_pct = 5;
    frame_no  = 0;
    target    = sb.live_items + 800;
    while (sb.live_items < target) begin
      set_idling(frame_no % 4);
      extreme_samples = ($urandom_range(9) == 0);
      pick = $urandom_range(99);
      if (pick < 3) begin
        w = $urandom_range(1) ? 0 : $urandom_range(1, 6);
        h = (w != 0) ? 0 : $urandom_range(0, 4);
      end else if (pick < 12) begin
        w = $urandom_range(17, 64);
        h = $urandom_range(1, 3);
      end else begin
        w = $urandom_range(1, 12);
        h = $urandom_range(1, 6);
      end
      ch = ($urandom_range(9) < 7) ? $urandom_range(1, 4) : $urandom_range(0, 7);
      configure(KernelW'($urandom_range(7)), w, h, ch);
      stream_frame(1 << 30);
      frame_no++;
    end

    // sizes past the maximum saturate, then shrink partway to keep the frame short
    noise_pct = 0;
    extreme_samples = 1'b0;
    set_idling(0);
    configure(K_GAUSS, 1025, 2, 4);
    stream_frame(20);
    configure(K_GAUSS, 22, 2, 4);
    stream_frame(1 << 30);
    set_idling(3);
    configure(K_SHARPEN, 1, 1025, 4);
    stream_frame(5);
    configure(K_SHARPEN, 1, 3, 4);
    stream_frame(1 << 30);

    settle();
    repeat (10) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending_pixels.size() == 0) begin
      $display("convolution_3x3_clamped_edges_tb: done, clean");
    end else begin
      $display("convolution_3x3_clamped_edges_tb: done, errors");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+design
design/c3x3_pkg.sv
design/c3x3_lane.sv
design/convolution_3x3_clamped_edges.sv
dv/convolution_3x3_clamped_edges_tb.sv
